/* rtl/core/sfcr_pkg.sv */
package sfcr_pkg;

    localparam int TIMER_W = 12;
    localparam int COUNT_W = 8;
    localparam int BITCNT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [TIMER_W-1:0] FIRST_TIMEOUT_RST = 12'd3000;
    localparam logic [TIMER_W-1:0] GAP_TIMEOUT_RST = 12'd200;
    localparam logic [COUNT_W-1:0] BYTE_LIMIT_RST = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_TIMEOUT = 3'd0,
        CFG_GAP_TIMEOUT   = 3'd1,
        CFG_ABORT_ENABLE  = 3'd2,
        CFG_BYTE_LIMIT    = 3'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        END_BUSY    = 2'd0,
        END_COUNT   = 2'd1,
        END_EXPIRED = 2'd2,
        END_ABORT   = 2'd3
    } t_end_status;

    typedef struct packed {
        logic cmd;
        logic clk_level;
        logic data_level;
        logic frame_level;
        logic ms_tick;
    } t_in_word;

    typedef struct packed {
        logic               byte_valid;
        logic [7:0]         byte_value;
        logic               done_res;
        t_end_status        end_status;
        logic [COUNT_W-1:0] received_count;
    } t_out_word;

    typedef struct packed {
        logic [TIMER_W-1:0] first_timeout_ms;
        logic [TIMER_W-1:0] gap_timeout_ms;
        logic               abort_enable;
        logic [COUNT_W-1:0] byte_limit;
    } t_cfg;

endpackage

/* rtl/core/serial_fill_cell_receiver_unit.sv */
// Serial fill cell receiver: each input word is a start command or one pin sample
// with a millisecond tick, and each accepted word yields exactly one result word.
// A word is taken every clock while the result side keeps up; its result shows up
// in the output register in the cycle after acceptance. The whole step (edge detect,
// shift, byte count, timer and end checks) is one combinational pass in front of
// that register, so it sustains one word per clock while the result side keeps up.
// Configuration writes are always ready and take effect for words accepted after the write.
module serial_fill_cell_receiver_unit import sfcr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_word res;
    logic      space;
    logic      accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready = space;
    assign accept = i_in_valid && space;

    sfcr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sfcr_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_in_word),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    sfcr_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_in_valid),
        .i_res   (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

/* rtl/core/sfcr_cfg.sv */
module sfcr_cfg import sfcr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_timeout_ms <= FIRST_TIMEOUT_RST;
            r_cfg.gap_timeout_ms <= GAP_TIMEOUT_RST;
            r_cfg.abort_enable <= 1'b1;
            r_cfg.byte_limit <= BYTE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIRST_TIMEOUT: r_cfg.first_timeout_ms <= i_cfg_data[TIMER_W-1:0];
                CFG_GAP_TIMEOUT:   r_cfg.gap_timeout_ms <= i_cfg_data[TIMER_W-1:0];
                CFG_ABORT_ENABLE:  r_cfg.abort_enable <= i_cfg_data[0];
                CFG_BYTE_LIMIT:    r_cfg.byte_limit <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/sfcr_step.sv */
module sfcr_step import sfcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_res
);

    logic               r_active;
    logic               r_last_clock;
    logic [7:0]         r_shift;
    logic [BITCNT_W-1:0] r_bits;
    logic [COUNT_W-1:0] r_bytes;
    logic [TIMER_W-1:0] r_timer;

    logic               n_active;
    logic               n_last_clock;
    logic [7:0]         n_shift;
    logic [BITCNT_W-1:0] n_bits;
    logic [COUNT_W-1:0] n_bytes;
    logic [TIMER_W-1:0] n_timer;
    t_out_word          res;

    always_comb begin
        n_active = r_active;
        n_last_clock = r_last_clock;
        n_shift = r_shift;
        n_bits = r_bits;
        n_bytes = r_bytes;
        n_timer = r_timer;
        res.byte_valid = 1'b0;
        res.byte_value = 8'd0;
        res.done_res = 1'b0;
        res.end_status = END_BUSY;
        res.received_count = r_bytes;
        if (i_word.cmd) begin
            n_active = 1'b1;
            n_last_clock = i_word.clk_level;
            n_bits = '0;
            n_bytes = '0;
            n_timer = i_cfg.first_timeout_ms;
            res.received_count = '0;
            if (i_cfg.first_timeout_ms == '0) begin
                n_active = 1'b0;
                res.done_res = 1'b1;
                res.end_status = END_EXPIRED;
            end else if (i_cfg.byte_limit == '0) begin
                n_active = 1'b0;
                res.done_res = 1'b1;
                res.end_status = END_COUNT;
            end
        end else if (r_active) begin
            // tick first, then timeout, abort, edge
            if (i_word.ms_tick && r_timer != '0) begin
                n_timer = r_timer - TIMER_W'(1);
            end
            if (n_timer == '0) begin
                n_active = 1'b0;
                res.done_res = 1'b1;
                res.end_status = END_EXPIRED;
            end else if (i_cfg.abort_enable && i_word.frame_level) begin
                n_active = 1'b0;
                n_bytes = '0;
                res.done_res = 1'b1;
                res.end_status = END_ABORT;
                res.received_count = '0;
            end else if (i_word.clk_level != r_last_clock) begin
                n_last_clock = i_word.clk_level;
                if (!i_word.clk_level) begin
                    n_shift = {~i_word.data_level, r_shift[7:1]};
                    n_bits = r_bits + BITCNT_W'(1);
                    if (n_bits == '0) begin
                        n_bytes = r_bytes + COUNT_W'(1);
                        n_timer = i_cfg.gap_timeout_ms;
                        res.byte_valid = 1'b1;
                        res.byte_value = n_shift;
                        res.received_count = n_bytes;
                        if (n_bytes >= i_cfg.byte_limit) begin
                            n_active = 1'b0;
                            res.done_res = 1'b1;
                            res.end_status = END_COUNT;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_last_clock <= 1'b0;
            r_shift <= '0;
            r_bits <= '0;
            r_bytes <= '0;
            r_timer <= '0;
        end else if (i_accept) begin
            r_active <= n_active;
            r_last_clock <= n_last_clock;
            r_shift <= n_shift;
            r_bits <= n_bits;
            r_bytes <= n_bytes;
            r_timer <= n_timer;
        end
    end

    assign o_res = res;

    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> (res.done_res == (res.end_status != END_BUSY)))
        else $error("done flag and end status disagree");

    a_abort_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && res.end_status == END_ABORT) |=> (r_bytes == '0 && !r_active))
        else $error("abort left count or session alive");

    a_byte_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && res.byte_valid) |=> (r_timer == $past(i_cfg.gap_timeout_ms)
            && r_bits == '0))
        else $error("byte did not reload gap timer");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !r_active && !i_word.cmd) |=> $stable(r_bytes) && !r_active)
        else $error("idle sample changed state");

endmodule

/* rtl/core/sfcr_out.sv */
module sfcr_out import sfcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_res,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    logic      r_valid;
    t_out_word r_word;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_space) begin
            r_word <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_word = r_word;

endmodule

/* tb/sfcr_result_checker.sv */
module sfcr_result_checker
    import sfcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_word             i_out_word,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_bytes_total,
    output int                    o_count_ends,
    output int                    o_timeout_ends,
    output int                    o_abort_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg                cfg_regs;
    logic                armed;
    logic                clk_seen;
    logic [7:0]          shifter;
    logic [BITCNT_W-1:0] bit_cnt;
    logic [COUNT_W-1:0]  rx_bytes;
    logic [TIMER_W-1:0]  ms_left;

    t_out_word due_words[$];
    t_out_word want;
    t_out_word got;
    int        fails;
    int        words_checked;
    int        bytes_seen;
    int        count_ends;
    int        timeout_ends;
    int        abort_ends;

    assign o_fail_count   = fails;
    assign o_bytes_total  = bytes_seen;
    assign o_count_ends   = count_ends;
    assign o_timeout_ends = timeout_ends;
    assign o_abort_ends   = abort_ends;

    task automatic close_cell(input t_end_status why, inout t_out_word r);
        armed = 1'b0;
        r.done_res = 1'b1;
        r.end_status = why;
        r.received_count = rx_bytes;
    endtask

    task automatic advance_cell(input t_in_word w, output t_out_word r);
        r = '0;
        if (w.cmd) begin
            armed = 1'b1;
            clk_seen = w.clk_level;
            bit_cnt = '0;
            rx_bytes = '0;
            ms_left = cfg_regs.first_timeout_ms;
            if (ms_left == '0) begin
                close_cell(END_EXPIRED, r);
            end else if (rx_bytes >= cfg_regs.byte_limit) begin
                close_cell(END_COUNT, r);
            end
        end else begin
            r.received_count = rx_bytes;
            if (armed) begin
                if (w.ms_tick && ms_left != '0) begin
                    ms_left = ms_left - TIMER_W'(1);
                end
                if (ms_left == '0) begin
                    close_cell(END_EXPIRED, r);
                end else if (cfg_regs.abort_enable && w.frame_level) begin
                    rx_bytes = '0;
                    close_cell(END_ABORT, r);
                end else if (w.clk_level != clk_seen) begin
                    clk_seen = w.clk_level;
                    if (!w.clk_level) begin
                        // line is active low, first bit ends up in bit zero
                        shifter = {~w.data_level, shifter[7:1]};
                        bit_cnt = bit_cnt + BITCNT_W'(1);
                        if (bit_cnt == '0) begin
                            rx_bytes = rx_bytes + COUNT_W'(1);
                            ms_left = cfg_regs.gap_timeout_ms;
                            r.byte_valid = 1'b1;
                            r.byte_value = shifter;
                            r.received_count = rx_bytes;
                            if (rx_bytes >= cfg_regs.byte_limit) begin
                                close_cell(END_COUNT, r);
                            end
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_regs.first_timeout_ms = FIRST_TIMEOUT_RST;
            cfg_regs.gap_timeout_ms = GAP_TIMEOUT_RST;
            cfg_regs.abort_enable = 1'b1;
            cfg_regs.byte_limit = BYTE_LIMIT_RST;
            armed = 1'b0;
            clk_seen = 1'b0;
            shifter = '0;
            bit_cnt = '0;
            rx_bytes = '0;
            ms_left = '0;
            due_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_FIRST_TIMEOUT: cfg_regs.first_timeout_ms = i_cfg_data[TIMER_W-1:0];
                    CFG_GAP_TIMEOUT:   cfg_regs.gap_timeout_ms = i_cfg_data[TIMER_W-1:0];
                    CFG_ABORT_ENABLE:  cfg_regs.abort_enable = i_cfg_data[0];
                    CFG_BYTE_LIMIT:    cfg_regs.byte_limit = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_word;
                words_checked++;
                if (due_words.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("result word %0d arrived with nothing pending: %h",
                                 words_checked, got);
                    end
                end else begin
                    want = due_words.pop_front();
                    if (got.byte_valid !== want.byte_valid
                            || got.byte_value !== want.byte_value
                            || got.done_res !== want.done_res
                            || got.end_status !== want.end_status
                            || got.received_count !== want.received_count) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("result word %0d mismatch", words_checked);
                            $display("    want valid=%0b byte=%02h done=%0b status=%0d count=%0d",
                                     want.byte_valid, want.byte_value, want.done_res,
                                     want.end_status, want.received_count);
                            $display("    got valid=%0b byte=%02h done=%0b status=%0d count=%0d",
                                     got.byte_valid, got.byte_value, got.done_res,
                                     got.end_status, got.received_count);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_cell(i_in_word, want);
                due_words.push_back(want);
                if (want.byte_valid) begin
                    bytes_seen++;
                end
                case (want.end_status)
                    END_COUNT:   count_ends++;
                    END_EXPIRED: timeout_ends++;
                    END_ABORT:   abort_ends++;
                    default: ;
                endcase
            end
        end
        o_pending <= due_words.size();
    end

endmodule

/* tb/serial_fill_cell_receiver_unit_test.sv */
module serial_fill_cell_receiver_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_BASE = 3'd4;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_word              in_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int bytes_total;
    int count_ends;
    int timeout_ends;
    int abort_ends;

    bit steady = 1'b0;
    int hold_max = 3;
    int tick_pct = 0;
    int frame_pct = 0;
    int items_sent = 0;
    int settings_loaded = 0;
    int quiet_cycles = 0;

    serial_fill_cell_receiver_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sfcr_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_word      (in_word),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_word     (out_word),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_bytes_total  (bytes_total),
        .o_count_ends   (count_ends),
        .o_timeout_ends (timeout_ends),
        .o_abort_ends   (abort_ends)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit take_break();
        return !steady && chance(13);
    endfunction

    always @(posedge clk) begin
        out_ready <= !take_break();
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input t_in_word w);
        if (take_break()) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (take_break());
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_sample(input logic c, input logic d, input logic f);
        t_in_word w;
        w.cmd = 1'b0;
        w.clk_level = c;
        w.data_level = d;
        w.frame_level = f;
        w.ms_tick = chance(tick_pct);
        send_word(w);
    endtask

    task automatic send_start();
        t_in_word w;
        w = t_in_word'($urandom());
        w.cmd = 1'b1;
        send_word(w);
    endtask

    task automatic send_noise();
        t_in_word w;
        w = t_in_word'($urandom());
        w.cmd = chance(12);
        send_word(w);
    endtask

    task automatic send_bit(input logic one);
        int n_high;
        int n_low;
        n_high = $urandom_range(1, hold_max);
        n_low = $urandom_range(1, hold_max);
        repeat (n_high) send_sample(1'b1, 1'($urandom_range(1)), chance(frame_pct));
        repeat (n_low) send_sample(1'b0, !one, chance(frame_pct));
    endtask

    task automatic send_byte(input logic [7:0] v);
        for (int i = 0; i < 8; i++) begin
            send_bit(v[i]);
        end
    endtask

    task automatic send_cell(input int n_bytes);
        send_start();
        repeat (n_bytes) send_byte(8'($urandom()));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_config(input logic [TIMER_W-1:0] first, input logic [TIMER_W-1:0] gap,
                               input logic abort, input logic [COUNT_W-1:0] limit);
        settle();
        write_reg(CFG_FIRST_TIMEOUT, first);
        write_reg(CFG_GAP_TIMEOUT, gap);
        write_reg(CFG_ABORT_ENABLE, CFG_DATA_W'({$urandom(), abort}));
        write_reg(CFG_BYTE_LIMIT, CFG_DATA_W'({$urandom(), limit}));
        // spare index, must be ignored
        write_reg(CFG_IDX_UNUSED_BASE | CFG_IDX_W'($urandom_range(3)), CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [TIMER_W-1:0] pick_timeout();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return TIMER_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_limit();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return COUNT_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if (chance(80)) begin
                send_cell($urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(1, 6)) send_noise();
            end
        end
    endtask

    initial begin
        t_in_word w;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle sample, partial byte, then frame abort
        tick_pct = 0;
        frame_pct = 0;
        hold_max = 1;
        w = '1;
        w.cmd = 1'b0;
        send_word(w);
        send_start();
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_sample(1'b1, 1'b0, 1'b1);

        // zero first timeout wins over zero limit
        load_config('0, GAP_TIMEOUT_RST, 1'b1, '0);
        send_start();
        load_config(TIMER_W'(7), GAP_TIMEOUT_RST, 1'b1, '0);
        send_start();

        // zero gap timeout expires the cell on the frame sample, abort off
        load_config('1, '0, 1'b0, '1);
        send_start();
        send_byte(8'hFF);
        send_sample(1'b1, 1'b1, 1'b1);

        hold_max = 3;
        frame_pct = 2;
        for (int p = 0; p < 9; p++) begin
            load_config(pick_timeout(), pick_timeout(), 1'($urandom_range(1)), pick_limit());
            tick_pct = 2 + 8 * $urandom_range(3);
            random_phase(40);
        end

        load_config(TIMER_W'(1), TIMER_W'(1), 1'b1, COUNT_W'(1));
        tick_pct = 20;
        random_phase(40);

        // long cell at the largest settings, no idling on either side
        load_config('1, '1, 1'b1, '1);
        steady = 1'b1;
        hold_max = 1;
        tick_pct = 1;
        frame_pct = 0;
        send_cell(30);
        settle();
        steady = 1'b0;

        load_config(FIRST_TIMEOUT_RST, GAP_TIMEOUT_RST, 1'b1, BYTE_LIMIT_RST);
        hold_max = 3;
        tick_pct = 10;
        frame_pct = 2;
        random_phase(40);

        settle();
        $display("%0d input words over %0d register settings, %0d bytes assembled",
                 items_sent, settings_loaded, bytes_total);
        $display("cells closed: %0d by count, %0d by timeout, %0d by abort",
                 count_ends, timeout_ends, abort_ends);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
